/* hdl/size_sorted_free_record_list_macros.svh */
// ----------------------------------------------------------------------------
// Size-sorted free record list assertion macros
// Concurrent assertion shorthands for the free record list; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef SIZE_SORTED_FREE_RECORD_LIST_MACROS_SVH
`define SIZE_SORTED_FREE_RECORD_LIST_MACROS_SVH

`ifndef SYNTHESIS

`define SFRL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sfrl: implication check failed");

`define SFRL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sfrl: next-cycle check failed");

`else

`define SFRL_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define SFRL_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* hdl/sfrl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Free record list package
// Field widths, operation and status codes, entry type and control structs.
// ----------------------------------------------------------------------------
package sfrl_pkg;

	localparam int CAPACITY_DEF = 32;

	localparam int FUNC_W  = 2;
	localparam int ID_W    = 31;
	localparam int SIZE_W  = 16;
	localparam int OFF_W   = 32;
	localparam int STAT_W  = 2;
	localparam int CNT_W   = 6;
	localparam int ENTRY_W = ID_W + SIZE_W + OFF_W;

	typedef logic [FUNC_W-1:0] sfrl_func_t;
	typedef logic [STAT_W-1:0] sfrl_status_t;

	localparam sfrl_func_t FUNC_INSERT = 2'd0;
	localparam sfrl_func_t FUNC_PEEK   = 2'd1;
	localparam sfrl_func_t FUNC_REMOVE = 2'd2;

	localparam sfrl_status_t STAT_OK    = 2'd0;
	localparam sfrl_status_t STAT_EMPTY = 2'd1;
	localparam sfrl_status_t STAT_FULL  = 2'd2;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [SIZE_W-1:0] size;
		logic [OFF_W-1:0]  off;
	} sfrl_entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_READ,
		S_SCAN,
		S_HEAD,
		S_FETCH
	} sfrl_state_t;

	typedef struct packed {
		logic         load;
		logic         step;
		logic         wr_shift;
		logic         wr_after;
		logic         wr_head;
		logic         pop;
		logic         out_load;
		logic         out_head;
		sfrl_status_t status;
	} sfrl_cmd_t;

	typedef struct packed {
		sfrl_func_t func;
		logic       empty;
		logic       full;
		logic       k_zero;
		logic       shift;
	} sfrl_stat_t;

endpackage

/* hdl/sfrl_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Free record list request channel
// Valid/ready channel carrying one operation and its insert payload.
// ----------------------------------------------------------------------------
interface sfrl_req_if
	import sfrl_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [FUNC_W-1:0]  func;
	logic [ID_W-1:0]    rec_id;
	logic [SIZE_W-1:0]  rec_size;
	logic [OFF_W-1:0]   byte_offset;

	modport source (output valid, func, rec_id, rec_size, byte_offset, input ready);
	modport sink   (input valid, func, rec_id, rec_size, byte_offset, output ready);
endinterface

/* hdl/sfrl_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Free record list response channel
// Valid/ready channel carrying status, head entry and entry count.
// ----------------------------------------------------------------------------
interface sfrl_rsp_if
	import sfrl_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [STAT_W-1:0]  status;
	logic [ID_W-1:0]    head_id;
	logic [SIZE_W-1:0]  head_size;
	logic [OFF_W-1:0]   head_offset;
	logic [CNT_W-1:0]   entry_count;

	modport source (output valid, status, head_id, head_size, head_offset, entry_count,
		input ready);
	modport sink   (input valid, status, head_id, head_size, head_offset, entry_count,
		output ready);
endinterface

/* hdl/size_sorted_free_record_list.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Size-sorted free record list
// Bounded worst-fit free record table kept in descending size order.
// ----------------------------------------------------------------------------
// Channel  Role   Handshake     Carries
// req      sink   valid/ready   func, rec_id, rec_size, byte_offset
// rsp      source valid/ready   status, head_id, head_size, head_offset, entry_count
//
// Insert into a non-empty table walks the RAM from the tail toward the head, one
// entry per cycle through the single write / registered read port, then writes
// the new entry. Insert into an empty table writes the head entry directly;
// peek/remove read the head entry; rejected ops respond from decode.
// Reset clears occupancy and the head pointer; the RAM needs no clearing.
// A held response stalls the op at its final step; req is taken only when idle.
// ----------------------------------------------------------------------------
`include "size_sorted_free_record_list_macros.svh"

module size_sorted_free_record_list
	import sfrl_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input logic        clk,
	input logic        arst_n,
	sfrl_req_if.sink   req,
	sfrl_rsp_if.source rsp
);

	sfrl_cmd_t  cmd;
	sfrl_stat_t stat;

	sfrl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sfrl_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_func    (req.func),
		.in_id      (req.rec_id),
		.in_size    (req.rec_size),
		.in_off     (req.byte_offset),
		.out_status (rsp.status),
		.out_id     (rsp.head_id),
		.out_size   (rsp.head_size),
		.out_off    (rsp.head_offset),
		.out_count  (rsp.entry_count)
	);

	`SFRL_ASSERT_IMP(a_one_write, clk, arst_n, 1'b1, $onehot0({cmd.wr_shift, cmd.wr_after, cmd.wr_head}))
	`SFRL_ASSERT_IMP(a_pop_nonempty, clk, arst_n, cmd.pop, !stat.empty && cmd.out_load)
	`SFRL_ASSERT_IMP(a_write_not_full, clk, arst_n, cmd.wr_after || cmd.wr_head, !stat.full)
	`SFRL_ASSERT_NXT(a_load_sets_valid, clk, arst_n, cmd.out_load, rsp.valid)

endmodule

/* hdl/sfrl_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sfrl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

/* hdl/sfrl_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Free record list controller
// Sequences decode, table walk, writes and the response register handoff.
// ----------------------------------------------------------------------------
module sfrl_ctrl
	import sfrl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  sfrl_stat_t stat,
	output sfrl_cmd_t  cmd
);

	sfrl_state_t state_q;
	sfrl_state_t state_d;
	logic        out_valid_q;
	logic        out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.status = STAT_OK;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (stat.func) inside
					FUNC_INSERT: begin
						if (stat.full) begin
							if (out_free) begin
								cmd.out_load = 1'b1;
								cmd.status   = STAT_FULL;
								state_d      = S_IDLE;
							end
						end else if (stat.empty) begin
							state_d = S_HEAD;
						end else begin
							state_d = S_READ;
						end
					end
					FUNC_PEEK, FUNC_REMOVE: begin
						if (stat.empty) begin
							if (out_free) begin
								cmd.out_load = 1'b1;
								cmd.status   = STAT_EMPTY;
								state_d      = S_IDLE;
							end
						end else begin
							state_d = S_READ;
						end
					end
					default: begin
						if (out_free) begin
							cmd.out_load = 1'b1;
							state_d      = S_IDLE;
						end
					end
				endcase
			end
			S_READ: begin
				state_d = (stat.func == FUNC_INSERT) ? S_SCAN : S_FETCH;
			end
			S_SCAN: begin
				if (stat.shift) begin
					cmd.wr_shift = 1'b1;
					if (stat.k_zero) begin
						state_d = S_HEAD;
					end else begin
						cmd.step = 1'b1;
					end
				end else if (out_free) begin
					cmd.wr_after = 1'b1;
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_HEAD: begin
				if (out_free) begin
					cmd.wr_head  = 1'b1;
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_FETCH: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_head = 1'b1;
					cmd.pop      = (stat.func == FUNC_REMOVE);
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* hdl/sfrl_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Free record list datapath
// Circular entry table, head pointer, occupancy, walk index and response register.
// ----------------------------------------------------------------------------
module sfrl_dpath
	import sfrl_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sfrl_cmd_t          cmd,
	output sfrl_stat_t         stat,
	input  logic [FUNC_W-1:0]  in_func,
	input  logic [ID_W-1:0]    in_id,
	input  logic [SIZE_W-1:0]  in_size,
	input  logic [OFF_W-1:0]   in_off,
	output logic [STAT_W-1:0]  out_status,
	output logic [ID_W-1:0]    out_id,
	output logic [SIZE_W-1:0]  out_size,
	output logic [OFF_W-1:0]   out_off,
	output logic [CNT_W-1:0]   out_count
);

	localparam int PW = $clog2(CAPACITY);
	localparam int OW = $clog2(CAPACITY + 1);
	localparam logic [PW:0]   CAP_X  = (PW + 1)'(CAPACITY);
	localparam logic [PW-1:0] LAST_P = PW'(CAPACITY - 1);
	localparam logic [OW-1:0] CAP_O  = OW'(CAPACITY);

	sfrl_func_t        func_q;
	sfrl_entry_t       new_q;
	logic [PW-1:0]     head_q;
	logic [OW-1:0]     occ_q;
	logic [OW-1:0]     occ_nxt;
	logic [PW-1:0]     k_q;
	logic [PW-1:0]     rd_idx;
	logic [PW-1:0]     wr_idx;
	logic [PW:0]       rd_sum;
	logic [PW:0]       wr_sum;
	logic [PW-1:0]     rd_addr;
	logic [PW-1:0]     wr_addr;
	logic              wr_en;
	logic              wr_new;
	sfrl_entry_t       wr_data;
	logic [ENTRY_W-1:0] rd_raw;
	sfrl_entry_t       rd_ent;
	sfrl_status_t      res_status_q;
	sfrl_entry_t       res_q;
	logic [CNT_W-1:0]  res_count_q;

	assign rd_ent = sfrl_entry_t'(rd_raw);

	assign rd_idx  = cmd.step ? (k_q - 1'b1) : k_q;
	assign wr_idx  = cmd.wr_head ? '0 : (k_q + 1'b1);
	assign rd_sum  = {1'b0, head_q} + {1'b0, rd_idx};
	assign wr_sum  = {1'b0, head_q} + {1'b0, wr_idx};
	assign rd_addr = (rd_sum >= CAP_X) ? PW'(rd_sum - CAP_X) : PW'(rd_sum);
	assign wr_addr = (wr_sum >= CAP_X) ? PW'(wr_sum - CAP_X) : PW'(wr_sum);

	assign wr_new  = cmd.wr_after || cmd.wr_head;
	assign wr_en   = wr_new || cmd.wr_shift;
	assign wr_data = cmd.wr_shift ? rd_ent : new_q;

	always_comb begin
		occ_nxt = occ_q;
		if (wr_new) begin
			occ_nxt = occ_q + 1'b1;
		end else if (cmd.pop) begin
			occ_nxt = occ_q - 1'b1;
		end
	end

	assign stat.func   = func_q;
	assign stat.empty  = (occ_q == '0);
	assign stat.full   = (occ_q == CAP_O);
	assign stat.k_zero = (k_q == '0);
	assign stat.shift  = (k_q != '0) ? (rd_ent.size <= new_q.size)
		: (rd_ent.size < new_q.size);

	sfrl_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			occ_q  <= '0;
			func_q <= FUNC_PEEK;
			k_q    <= '0;
		end else begin
			occ_q <= occ_nxt;
			if (cmd.pop) begin
				head_q <= (head_q == LAST_P) ? '0 : (head_q + 1'b1);
			end
			if (cmd.load) begin
				func_q <= in_func;
				k_q    <= (in_func == FUNC_INSERT) ? PW'(occ_q - 1'b1) : '0;
			end else if (cmd.step) begin
				k_q <= k_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			new_q.id   <= in_id;
			new_q.size <= in_size;
			new_q.off  <= in_off;
		end
		if (cmd.out_load) begin
			res_status_q <= cmd.status;
			res_q        <= cmd.out_head ? rd_ent : '0;
			res_count_q  <= CNT_W'(occ_nxt);
		end
	end

	assign out_status = res_status_q;
	assign out_id     = res_q.id;
	assign out_size   = res_q.size;
	assign out_off    = res_q.off;
	assign out_count  = res_count_q;

endmodule
